// File: hdl/bmsc_pkg.sv
// Package with the shared types, constants and codes of the BGP message stream checker.
package bmsc_pkg;

    localparam int MARKER_BYTES = 16;
    localparam int COUNT_WIDTH  = 32;
    localparam int LEN_WIDTH    = 16;
    localparam int CNT_WIDTH    = 16;

    localparam logic [LEN_WIDTH-1:0] MIN_MSG_LEN = LEN_WIDTH'(MARKER_BYTES + 3);
    localparam logic [CNT_WIDTH-1:0] MARKER_LAST = CNT_WIDTH'(MARKER_BYTES - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TRUNC_HDR  = 2'd1;
    localparam logic [1:0] ST_BAD_LEN    = 2'd2;
    localparam logic [1:0] ST_TRUNC_BODY = 2'd3;

    localparam logic [1:0] CFG_MAX_LEN      = 2'd0;
    localparam logic [1:0] CFG_COUNTED_TYPE = 2'd1;
    localparam logic [1:0] CFG_DECODE_EN    = 2'd2;

    localparam logic [15:0] MAX_LEN_RESET      = 16'd4096;
    localparam logic [7:0]  COUNTED_TYPE_RESET = 8'd2;

    typedef enum logic [2:0] {
        PH_MARKER = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_TYPE   = 3'd3,
        PH_BODY   = 3'd4,
        PH_ERROR  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } bmsc_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] message_count;
    } bmsc_out_t;

    typedef struct packed {
        logic [LEN_WIDTH-1:0] max_message_length;
        logic [7:0]           counted_type;
        logic                 decode_enable;
    } bmsc_cfg_t;

endpackage

// File: hdl/bmsc_framer.sv
// Framing state machine that walks the message stream one byte at a time.
module bmsc_framer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  bmsc_pkg::bmsc_in_t  item,
    input  bmsc_pkg::bmsc_cfg_t cfg,
    output logic                res_valid,
    output bmsc_pkg::bmsc_out_t res_data
);
    import bmsc_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [CNT_WIDTH-1:0]   byte_counter_reg, byte_counter_next;
    logic [LEN_WIDTH-1:0]   length_reg, length_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [1:0]             error_reg, error_next;
    logic [LEN_WIDTH-1:0]   body_len;
    logic [1:0]             end_status;

    assign body_len = length_reg - MIN_MSG_LEN;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_MARKER;
            byte_counter_reg <= '0;
            length_reg       <= '0;
            count_reg        <= '0;
            error_reg        <= ST_OK;
        end
        else
        begin
            phase_reg        <= phase_next;
            byte_counter_reg <= byte_counter_next;
            length_reg       <= length_next;
            count_reg        <= count_next;
            error_reg        <= error_next;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        byte_counter_next = byte_counter_reg;
        length_next       = length_reg;
        count_next        = count_reg;
        error_next        = error_reg;
        end_status        = ST_OK;
        res_valid         = 1'b0;
        res_data.status        = ST_OK;
        res_data.message_count = '0;

        if (step && cfg.decode_enable)
        begin
            case (phase_reg)
                PH_MARKER:
                begin
                    if (byte_counter_reg >= MARKER_LAST)
                    begin
                        byte_counter_next = '0;
                        phase_next        = PH_LEN_HI;
                    end
                    else
                    begin
                        byte_counter_next = byte_counter_reg + 1'b1;
                    end
                end
                PH_LEN_HI:
                begin
                    length_next = {item.data_byte, 8'h00};
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_next = {length_reg[15:8], item.data_byte};
                    phase_next  = PH_TYPE;
                end
                PH_TYPE:
                begin
                    if (length_reg < MIN_MSG_LEN || length_reg > cfg.max_message_length)
                    begin
                        error_next = ST_BAD_LEN;
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        if (item.data_byte == cfg.counted_type && count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        byte_counter_next = body_len;
                        phase_next        = (body_len == '0) ? PH_MARKER : PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    byte_counter_next = byte_counter_reg - 1'b1;
                    if (byte_counter_reg == CNT_WIDTH'(1))
                    begin
                        phase_next = PH_MARKER;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (error_next != ST_OK)
        begin
            end_status = error_next;
        end
        else if (phase_next == PH_MARKER)
        begin
            end_status = (byte_counter_next == '0) ? ST_OK : ST_TRUNC_HDR;
        end
        else if (phase_next == PH_BODY)
        begin
            end_status = ST_TRUNC_BODY;
        end
        else
        begin
            end_status = ST_TRUNC_HDR;
        end

        if (step && item.last_byte)
        begin
            res_valid = 1'b1;
            if (cfg.decode_enable)
            begin
                res_data.status        = end_status;
                res_data.message_count = (end_status == ST_OK) ? count_next : '0;
            end
            phase_next        = PH_MARKER;
            byte_counter_next = '0;
            length_next       = '0;
            count_next        = '0;
            error_next        = ST_OK;
        end
    end

    a_error_phase_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |-> error_reg != ST_OK)
        else $error("Error phase without an error code.");

    a_marker_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_MARKER |-> byte_counter_reg <= MARKER_LAST)
        else $error("Marker byte count ran past the marker.");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last_byte |=> phase_reg == PH_MARKER && byte_counter_reg == '0
            && count_reg == '0 && error_reg == ST_OK)
        else $error("Stream state not cleared after the final word.");

endmodule

// File: hdl/bgp_message_stream_checker_top.sv
// Top level of the BGP message stream checker with input, result and configuration ports.
// The checker takes one word per cycle, back to back, and each word is a stream byte with a
// last-byte flag. A word is held in an input register; when it advances, the framing state is
// updated and the result of a final word is loaded into the result register, from which it is
// offered. The rate is one word per cycle; a result waiting in the result register stalls the
// input only when the next final word reaches it and the receiver is not ready. Configuration
// writes are always taken at once and must only be issued while the checker is idle.
module bgp_message_stream_checker_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bmsc_pkg::bmsc_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bmsc_pkg::bmsc_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import bmsc_pkg::*;

    bmsc_cfg_t cfg_reg;
    bmsc_in_t  in_reg;
    logic      in_valid_reg;
    bmsc_out_t out_reg;
    logic      out_valid_reg;
    logic      advance;
    logic      res_valid;
    bmsc_out_t res_data;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!in_reg.last_byte || !out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_message_length <= MAX_LEN_RESET;
            cfg_reg.counted_type       <= COUNTED_TYPE_RESET;
            cfg_reg.decode_enable      <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_LEN:      cfg_reg.max_message_length <= cfg_data;
                CFG_COUNTED_TYPE: cfg_reg.counted_type       <= cfg_data[7:0];
                CFG_DECODE_EN:    cfg_reg.decode_enable      <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
        if (res_valid)
        begin
            out_reg <= res_data;
        end
    end

    bmsc_framer u_framer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    a_middle_word_flows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !in_reg.last_byte |-> advance)
        else $error("A word that is not final was held back.");

    a_error_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status != ST_OK |-> out_reg.message_count == '0)
        else $error("Error result carries a nonzero count.");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && in_reg.last_byte && out_valid_reg && !out_ready)
        else $error("Input stalled without a pending result.");

endmodule

// File: tb/bmsc_framing_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the framing verdict of every byte stream and compares each result word.
module bmsc_framing_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  bmsc_pkg::bmsc_in_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  bmsc_pkg::bmsc_out_t out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output int                  mismatches,
    output int                  outstanding,
    output int                  verdicts_seen
);
    import bmsc_pkg::*;

    logic [15:0]            max_len_reg;
    logic [7:0]             count_type_reg;
    logic                   decode_on;

    phase_t                 frame_phase;
    logic [15:0]            frame_bytes;
    logic [15:0]            frame_len;
    logic [7:0]             frame_type;
    logic [COUNT_WIDTH-1:0] counted_msgs;
    logic [1:0]             stream_error;

    bmsc_out_t              awaited_verdicts[$];
    bmsc_out_t              oldest;

    task automatic clear_stream();
        frame_phase  = PH_MARKER;
        frame_bytes  = '0;
        frame_len    = '0;
        frame_type   = '0;
        counted_msgs = '0;
        stream_error = ST_OK;
    endtask

    task automatic track_framing(input bmsc_in_t w);
        bmsc_out_t verdict;
        if (!decode_on) begin
            if (w.last_byte) begin
                verdict.status        = ST_OK;
                verdict.message_count = '0;
                awaited_verdicts.push_back(verdict);
                clear_stream();
            end
        end else begin
            case (frame_phase)
                PH_MARKER: begin
                    frame_bytes = frame_bytes + 16'd1;
                    if (frame_bytes >= MARKER_BYTES) begin
                        frame_bytes = '0;
                        frame_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    frame_len   = {w.data_byte, 8'h00};
                    frame_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    frame_len   = frame_len | {8'h00, w.data_byte};
                    frame_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    frame_type = w.data_byte;
                    if (frame_len < MIN_MSG_LEN || frame_len > max_len_reg) begin
                        stream_error = ST_BAD_LEN;
                        frame_phase  = PH_ERROR;
                    end else begin
                        if (frame_type == count_type_reg && counted_msgs != COUNT_MAX)
                            counted_msgs = counted_msgs + 1'b1;
                        frame_bytes = frame_len - MIN_MSG_LEN;
                        if (frame_bytes == 0)
                            frame_phase = PH_MARKER;
                        else
                            frame_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    frame_bytes = frame_bytes - 16'd1;
                    if (frame_bytes == 0)
                        frame_phase = PH_MARKER;
                end
                default: begin
                end
            endcase
            if (w.last_byte) begin
                if (stream_error != ST_OK)
                    verdict.status = stream_error;
                else if (frame_phase == PH_MARKER)
                    verdict.status = (frame_bytes == 0) ? ST_OK : ST_TRUNC_HDR;
                else if (frame_phase == PH_BODY)
                    verdict.status = ST_TRUNC_BODY;
                else
                    verdict.status = ST_TRUNC_HDR;
                verdict.message_count = (verdict.status == ST_OK) ? counted_msgs : '0;
                awaited_verdicts.push_back(verdict);
                clear_stream();
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_len_reg    = MAX_LEN_RESET;
            count_type_reg = COUNTED_TYPE_RESET;
            decode_on      = 1'b1;
            clear_stream();
            awaited_verdicts.delete();
            mismatches     = 0;
            outstanding    = 0;
            verdicts_seen  = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (awaited_verdicts.size() == 0) begin
                    $error("Result word with status %0d and message_count %0d was not expected.",
                           out_data.status, out_data.message_count);
                    mismatches = mismatches + 1;
                end else begin
                    oldest        = awaited_verdicts.pop_front();
                    verdicts_seen = verdicts_seen + 1;
                    if (out_data.status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d",
                               oldest.status, out_data.status);
                        mismatches = mismatches + 1;
                    end
                    if (out_data.message_count !== oldest.message_count) begin
                        $error("message_count: expected %0d, actual %0d",
                               oldest.message_count, out_data.message_count);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MAX_LEN:      max_len_reg    = cfg_data;
                    CFG_COUNTED_TYPE: count_type_reg = cfg_data[7:0];
                    CFG_DECODE_EN:    decode_on      = cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (in_valid && in_ready)
                track_framing(in_data);
            outstanding = awaited_verdicts.size();
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top with clock, reset, stream stimulus, idling, the checker instance and the verdict.
module tb_top;
    import bmsc_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    bmsc_in_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    bmsc_out_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_MAX_LEN;
    logic [15:0] cfg_data  = '0;

    int mismatches;
    int outstanding;
    int verdicts_seen;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int words_sent    = 0;
    int streams_sent  = 0;
    int settings_used = 0;

    logic [15:0] cur_max_len = MAX_LEN_RESET;
    logic [7:0]  cur_type    = COUNTED_TYPE_RESET;
    logic [7:0]  stream_bytes[$];

    bgp_message_stream_checker_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bmsc_framing_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .verdicts_seen (verdicts_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d results outstanding.", outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            out_ready    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_word(input logic [7:0] value, input logic is_last);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: value, last_byte: is_last};
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic send_bytes(input int count, input logic ends_stream);
        for (int k = 0; k < count; k++)
            send_word(stream_bytes.pop_front(), ends_stream && k == count - 1);
    endtask

    task automatic send_stream();
        send_bytes(stream_bytes.size(), 1'b1);
        streams_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [15:0] max_len, input logic [7:0] mtype,
                                  input logic enable);
        write_register(CFG_MAX_LEN, max_len);
        write_register(CFG_COUNTED_TYPE, {8'($urandom_range(255)), mtype});
        write_register(CFG_DECODE_EN, {15'($urandom_range(32767)), enable});
        cfg_valid <= 1'b0;
        cur_max_len = max_len;
        cur_type    = mtype;
        settings_used++;
    endtask

    task automatic add_body(input int unsigned n);
        repeat (n) stream_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic add_header(input logic [15:0] len, input logic [7:0] mtype);
        add_body(MARKER_BYTES);
        stream_bytes.push_back(len[15:8]);
        stream_bytes.push_back(len[7:0]);
        stream_bytes.push_back(mtype);
    endtask

    task automatic trim_stream(input int unsigned keep);
        logic [7:0] dropped;
        while (stream_bytes.size() > keep)
            dropped = stream_bytes.pop_back();
    endtask

    function automatic logic [15:0] pick_length();
        int unsigned pick;
        pick = $urandom_range(9);
        case (pick)
            0: return 16'($urandom_range(MIN_MSG_LEN - 1));
            1: return (cur_max_len == 16'hFFFF) ? 16'hFFFF
                                                : 16'($urandom_range(65535, cur_max_len + 1));
            2: return (cur_max_len >= MIN_MSG_LEN && cur_max_len <= 16'd64) ? cur_max_len
                                                                              : MIN_MSG_LEN;
            default: return MIN_MSG_LEN + 16'($urandom_range(13));
        endcase
    endfunction

    task automatic random_stream();
        int unsigned kind;
        int unsigned msgs;
        int unsigned body;
        logic [15:0] len;
        logic        capped;
        kind   = $urandom_range(99);
        capped = 1'b0;
        if (kind < 12)
        begin
            add_body(1 + $urandom_range(29));
        end
        else
        begin
            msgs = 1 + $urandom_range(3);
            for (int m = 0; m < msgs && !capped; m++)
            begin
                len = pick_length();
                add_header(len, ($urandom_range(1) == 0) ? cur_type : 8'($urandom_range(255)));
                if (len >= MIN_MSG_LEN && len <= cur_max_len)
                    body = len - MIN_MSG_LEN;
                else
                    body = $urandom_range(3);
                if (body > 48)
                begin
                    body   = $urandom_range(48);
                    capped = 1'b1;
                end
                add_body(body);
            end
            if (kind < 32)
                trim_stream(1 + $urandom_range(stream_bytes.size() - 1));
        end
        send_stream();
    endtask

    task automatic run_phase(input logic [15:0] max_len, input logic [7:0] mtype,
                             input logic enable, input int send_pct, input int stall,
                             input int words);
        int phase_end;
        int phase_streams;
        apply_settings(max_len, mtype, enable);
        send_idle_pct = send_pct;
        stall_pct     = stall;
        phase_end     = words_sent + words;
        phase_streams = 0;
        while (words_sent < phase_end || phase_streams < 8)
        begin
            random_stream();
            phase_streams++;
            if ($urandom_range(24) == 0)
                settle();
        end
        settle();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed streams under the reset values of the registers.
        stream_bytes.push_back(8'h00);
        send_stream();
        add_header(MIN_MSG_LEN, COUNTED_TYPE_RESET);
        send_stream();
        add_header(MIN_MSG_LEN, COUNTED_TYPE_RESET);
        add_body(1);
        send_stream();
        add_body(MARKER_BYTES - 1);
        send_stream();
        add_header(16'd30, 8'h00);
        trim_stream(MARKER_BYTES + 1);
        send_stream();
        add_header(16'd30, 8'h00);
        trim_stream(MARKER_BYTES + 2);
        send_stream();
        add_header(16'd21, COUNTED_TYPE_RESET);
        add_body(1);
        send_stream();
        add_header(16'd5, 8'hFF);
        add_body(2);
        send_stream();
        add_header(MAX_LEN_RESET + 16'd1, COUNTED_TYPE_RESET);
        add_header(MIN_MSG_LEN, COUNTED_TYPE_RESET);
        send_stream();
        add_header(MAX_LEN_RESET, COUNTED_TYPE_RESET);
        add_body(3);
        send_stream();
        add_header(16'd20, COUNTED_TYPE_RESET);
        add_body(1);
        add_header(MIN_MSG_LEN, 8'h07);
        add_header(MIN_MSG_LEN, COUNTED_TYPE_RESET);
        send_stream();

        // Bytes taken while decoding is off must not disturb a message in progress.
        add_header(MIN_MSG_LEN, COUNTED_TYPE_RESET);
        send_bytes(10, 1'b0);
        settle();
        write_register(CFG_DECODE_EN, 16'd0);
        cfg_valid <= 1'b0;
        repeat (3) send_word(8'($urandom_range(255)), 1'b0);
        settle();
        write_register(CFG_DECODE_EN, 16'd1);
        cfg_valid <= 1'b0;
        send_stream();
        settle();

        run_phase(MAX_LEN_RESET, COUNTED_TYPE_RESET, 1'b1, 0, 0, 250);
        run_phase(MIN_MSG_LEN, 8'h00, 1'b1, 58, 0, 250);
        run_phase(16'hFFFF, 8'hFF, 1'b1, 0, 58, 300);

        // The receiver holds off while short streams keep arriving, so the input backs up.
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_requests++;
        repeat (40)
        begin
            add_body(1 + $urandom_range(2));
            send_stream();
        end
        settle();

        run_phase(16'($urandom_range(64, 19)), 8'($urandom_range(255)), 1'b1, 34, 34, 400);
        run_phase(16'd0, 8'($urandom_range(255)), 1'b1, 0, 0, 120);
        run_phase(16'h1234, 8'h55, 1'b0, 58, 58, 150);
        run_phase(16'd40, COUNTED_TYPE_RESET, 1'b1, 34, 34, 400);

        $display("Checked %0d stream results from %0d words in %0d streams under %0d settings.",
                 verdicts_seen, words_sent, streams_sent, settings_used);
        $display("The run covered all framing errors, decoding off, idle, stall and back-pressure.");
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
hdl/bmsc_pkg.sv
hdl/bmsc_framer.sv
hdl/bgp_message_stream_checker_top.sv
tb/bmsc_framing_checker.sv
tb/tb_top.sv
